// ===== rtl/v3au_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// v3au_pkg
// Shared widths, opcodes, pipeline records and saturation helpers for the
// three-component fixed-point vector unit.
// ---------------------------------------------------------------------------
package v3au_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int W       = WORD_BITS;
  localparam int F       = FRAC_BITS;
  localparam int PW      = 2 * W;           // one full product
  localparam int SUMW    = 2 * W + 2;       // sum of three products
  localparam int NW      = W + F;           // dividend and quotient width
  localparam int LATENCY = 5 + W + NW;      // register stages from accept through the last divider stage

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_SCALE  = 4'd4,
    OP_DIVS   = 4'd5,
    OP_DOT    = 4'd6,
    OP_CROSS  = 4'd7,
    OP_MAG    = 4'd8,
    OP_NORM   = 4'd9,
    OP_NEG    = 4'd10
  } op_t;

  typedef logic [W-1:0]  word_t;
  typedef logic [NW-1:0] num_t;

  localparam word_t MAXW = {1'b0, {(W-1){1'b1}}};
  localparam word_t MINW = {1'b1, {(W-1){1'b0}}};
  localparam num_t  QMIN = {{(NW-W+1){1'b0}}, {(W-1){1'b0}}} | (num_t'(1) << (W-1));

  // Per-item record carried down the pipeline
  typedef struct packed {
    logic [3:0]           func;
    logic [2:0][W-1:0]    r;
    logic [W-1:0]         sc;
    logic                 ovf;
    logic [2:0][NW-1:0]   dvd;
    logic [2:0]           dvd_neg;
    logic [2:0][W-1:0]    dsr;
    logic [2:0]           dsr_neg;
  } pay_t;

  typedef struct packed {
    logic          vld;
    logic [PW-1:0] rad;
    logic [W+1:0]  rem;
    logic [W-1:0]  root;
    pay_t          pay;
  } sq_t;

  typedef struct packed {
    logic [W-1:0]  rem;
    logic [NW-1:0] num;
  } dlane_t;

  typedef struct packed {
    logic             vld;
    dlane_t [2:0]     lane;
    pay_t             pay;
  } dv_t;

  typedef struct packed {
    logic [W-1:0] val;
    logic         ovf;
  } sat_t;

  function automatic word_t abs_w(input logic [W-1:0] v);
    abs_w = v[W-1] ? (~v + word_t'(1)) : v;
  endfunction

  // Floor-shift a wide signed value by F and clamp to the word
  function automatic sat_t sat_shr(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] t;
    logic signed [SUMW-1:0] hi_lim;
    logic signed [SUMW-1:0] lo_lim;
    sat_t r;
    t      = v >>> F;
    hi_lim = $signed({{(SUMW-W+1){1'b0}}, {(W-1){1'b1}}});
    lo_lim = $signed({{(SUMW-W+1){1'b1}}, {(W-1){1'b0}}});
    if (t > hi_lim) begin
      r.val = MAXW;
      r.ovf = 1'b1;
    end else if (t < lo_lim) begin
      r.val = MINW;
      r.ovf = 1'b1;
    end else begin
      r.val = t[W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // Apply sign to an unsigned quotient and clamp to the word
  function automatic sat_t sat_quo(input num_t q, input logic neg);
    logic  big;
    word_t nq;
    sat_t  r;
    big = (q[NW-1:W-1] != '0);
    nq  = ~q[W-1:0] + word_t'(1);
    if (!neg) begin
      r.ovf = big;
      r.val = big ? MAXW : q[W-1:0];
    end else begin
      r.ovf = big && (q != QMIN);
      r.val = r.ovf ? MINW : nq;
    end
    return r;
  endfunction

  // Clamp an unsigned magnitude to the signed word
  function automatic sat_t sat_mag(input word_t m);
    sat_t r;
    r.ovf = m[W-1];
    r.val = m[W-1] ? MAXW : m;
    return r;
  endfunction

  function automatic logic is_div_op(input logic [3:0] f);
    return (f == OP_DIV) || (f == OP_DIVS) || (f == OP_NORM);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/v3au_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// v3au_front
// Four register stages: capture operands, multiply, combine products, and
// clamp every result but the magnitude and the divisions. Also prepares dividends and divisors.
// ---------------------------------------------------------------------------
module v3au_front import v3au_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_vld,
  input  wire logic [3:0]        in_func,
  input  wire logic [2:0][W-1:0] in_a,
  input  wire logic [2:0][W-1:0] in_b,
  input  wire logic [W-1:0]      in_s,
  output sq_t                    out
);

  // Stage A: operand capture
  logic              s1_vld;
  logic [3:0]        s1_func;
  logic [2:0][W-1:0] s1_a;
  logic [2:0][W-1:0] s1_b;
  logic [W-1:0]      s1_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_vld;
    end
    s1_func <= in_func;
    s1_a    <= in_a;
    s1_b    <= in_b;
    s1_s    <= in_s;
  end

  // Stage B: operand steering and multipliers
  logic signed [W-1:0]  ma [6];
  logic signed [W-1:0]  mb [6];
  logic signed [W:0]    lin [3];
  logic [2:0][W-1:0]    dsr;
  logic [2:0]           dsr_neg;
  logic [2:0][NW-1:0]   dvd;
  logic [2:0]           dvd_neg;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      lin[i]     = '0;
      dsr[i]     = '0;
      dsr_neg[i] = 1'b0;
      dvd[i]     = {abs_w(s1_a[i]), {F{1'b0}}};
      dvd_neg[i] = s1_a[i][W-1];
    end
    unique case (op_t'(s1_func))
      OP_ADD: begin
        for (int i = 0; i < 3; i++)
          lin[i] = $signed({s1_a[i][W-1], s1_a[i]}) + $signed({s1_b[i][W-1], s1_b[i]});
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++)
          lin[i] = $signed({s1_a[i][W-1], s1_a[i]}) - $signed({s1_b[i][W-1], s1_b[i]});
      end
      OP_NEG: begin
        for (int i = 0; i < 3; i++)
          lin[i] = -$signed({s1_a[i][W-1], s1_a[i]});
      end
      OP_MUL, OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = s1_a[i];
          mb[i] = s1_b[i];
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = s1_a[i];
          mb[i] = s1_s;
        end
      end
      OP_MAG, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = s1_a[i];
          mb[i] = s1_a[i];
        end
      end
      OP_CROSS: begin
        ma[0] = s1_a[1]; mb[0] = s1_b[2];
        ma[1] = s1_a[2]; mb[1] = s1_b[0];
        ma[2] = s1_a[0]; mb[2] = s1_b[1];
        ma[3] = s1_a[2]; mb[3] = s1_b[1];
        ma[4] = s1_a[0]; mb[4] = s1_b[2];
        ma[5] = s1_a[1]; mb[5] = s1_b[0];
      end
      OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          dsr[i]     = abs_w(s1_b[i]);
          dsr_neg[i] = s1_b[i][W-1];
        end
      end
      OP_DIVS: begin
        for (int i = 0; i < 3; i++) begin
          dsr[i]     = abs_w(s1_s);
          dsr_neg[i] = s1_s[W-1];
        end
      end
      default: begin
      end
    endcase
  end

  logic                 s2_vld;
  logic [3:0]           s2_func;
  logic signed [PW-1:0] s2_p [6];
  logic signed [W:0]    s2_lin [3];
  logic [2:0][NW-1:0]   s2_dvd;
  logic [2:0]           s2_dvd_neg;
  logic [2:0][W-1:0]    s2_dsr;
  logic [2:0]           s2_dsr_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_func <= s1_func;
    for (int i = 0; i < 6; i++) s2_p[i] <= ma[i] * mb[i];
    for (int i = 0; i < 3; i++) s2_lin[i] <= lin[i];
    s2_dvd     <= dvd;
    s2_dvd_neg <= dvd_neg;
    s2_dsr     <= dsr;
    s2_dsr_neg <= dsr_neg;
  end

  // Stage C: combine products into per-component wide values
  logic signed [SUMW-1:0] comp [3];
  logic signed [SUMW-1:0] psum;

  always_comb begin
    psum = SUMW'(s2_p[0]) + SUMW'(s2_p[1]) + SUMW'(s2_p[2]);
    for (int i = 0; i < 3; i++) begin
      comp[i] = '0;
      unique case (op_t'(s2_func))
        OP_ADD, OP_SUB, OP_NEG: comp[i] = SUMW'(s2_lin[i]) <<< F;
        OP_MUL, OP_SCALE:       comp[i] = SUMW'(s2_p[i]);
        OP_CROSS:               comp[i] = SUMW'(s2_p[i]) - SUMW'(s2_p[i+3]);
        default:                comp[i] = '0;
      endcase
    end
  end

  logic                   s3_vld;
  logic [3:0]             s3_func;
  logic signed [SUMW-1:0] s3_comp [3];
  logic signed [SUMW-1:0] s3_sum;
  logic [2:0][NW-1:0]     s3_dvd;
  logic [2:0]             s3_dvd_neg;
  logic [2:0][W-1:0]      s3_dsr;
  logic [2:0]             s3_dsr_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_func <= s2_func;
    for (int i = 0; i < 3; i++) s3_comp[i] <= comp[i];
    s3_sum     <= psum;
    s3_dvd     <= s2_dvd;
    s3_dvd_neg <= s2_dvd_neg;
    s3_dsr     <= s2_dsr;
    s3_dsr_neg <= s2_dsr_neg;
  end

  // Stage D: clamp and pick the fields each opcode drives
  sat_t cs [3];
  sat_t ds;
  pay_t pay;

  always_comb begin
    for (int i = 0; i < 3; i++) cs[i] = sat_shr(s3_comp[i]);
    ds          = sat_shr(s3_sum);
    pay.func    = s3_func;
    pay.r       = '0;
    pay.sc      = '0;
    pay.ovf     = 1'b0;
    pay.dvd     = s3_dvd;
    pay.dvd_neg = s3_dvd_neg;
    pay.dsr     = s3_dsr;
    pay.dsr_neg = s3_dsr_neg;
    unique case (op_t'(s3_func))
      OP_ADD, OP_SUB, OP_MUL, OP_SCALE, OP_CROSS, OP_NEG: begin
        for (int i = 0; i < 3; i++) pay.r[i] = cs[i].val;
        pay.ovf = cs[0].ovf | cs[1].ovf | cs[2].ovf;
      end
      OP_DOT: begin
        pay.sc  = ds.val;
        pay.ovf = ds.ovf;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.vld <= 1'b0;
    end else begin
      out.vld <= s3_vld;
    end
    out.rad  <= s3_sum[PW-1:0];
    out.rem  <= '0;
    out.root <= '0;
    out.pay  <= pay;
  end

endmodule
`default_nettype wire

// ===== rtl/v3au_sqrt_stage.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// v3au_sqrt_stage
// One root bit of the digit-by-digit integer square root, registered.
// ---------------------------------------------------------------------------
module v3au_sqrt_stage import v3au_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  sq_t       d,
  output sq_t       q
);

  logic [W+1:0] rem2;
  logic [W+1:0] trial;
  logic         take;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem2  = {d.rem[W-1:0], d.rad[PW-1 -: 2]};
    trial = {d.root, 2'b01};
    take  = (rem2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else begin
      q.vld <= d.vld;
    end
    q.rad  <= {d.rad[PW-3:0], 2'b00};
    q.rem  <= take ? (rem2 - trial) : rem2;
    q.root <= {d.root[W-2:0], take};
    q.pay  <= d.pay;
  end

endmodule
`default_nettype wire

// ===== rtl/v3au_div_stage.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// v3au_div_stage
// One quotient bit of restoring division for all three lanes, registered.
// ---------------------------------------------------------------------------
module v3au_div_stage import v3au_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  dv_t       d,
  output dv_t       q
);

  logic   [W:0] rem2 [3];
  logic   [W:0] dd   [3];
  logic   [2:0] take;
  dlane_t       nxt  [3];

  // Shift in the next dividend bit and subtract where the divisor fits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem2[i] = {d.lane[i].rem, d.lane[i].num[NW-1]};
      dd[i]   = {1'b0, d.pay.dsr[i]};
      take[i] = (rem2[i] >= dd[i]);
      nxt[i].rem = take[i] ? W'(rem2[i] - dd[i]) : rem2[i][W-1:0];
      nxt[i].num = {d.lane[i].num[NW-2:0], take[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else begin
      q.vld <= d.vld;
    end
    for (int i = 0; i < 3; i++) q.lane[i] <= nxt[i];
    q.pay <= d.pay;
  end

endmodule
`default_nettype wire

// ===== rtl/vec3_arithmetic_unit_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vec3_arithmetic_unit_top
// Fully pipelined three-component vector ALU in signed Q16.16.
// ---------------------------------------------------------------------------
// Accepts one transaction every clock (busy is high only during reset) and
// returns its result, marked by done, after passing every stage below
// (figures for Q16.16): four front stages hold the multipliers and
// saturation, one stage per root bit runs the square root (32), one stage
// settles the magnitude, one stage per quotient bit runs the three dividers
// (48), and one register drives the ports. Every opcode takes the same path,
// so results leave in order; the receiver has no way to stall them.
module vec3_arithmetic_unit_top import v3au_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         func,
  input  wire logic signed [W-1:0] a_x,
  input  wire logic signed [W-1:0] a_y,
  input  wire logic signed [W-1:0] a_z,
  input  wire logic signed [W-1:0] b_x,
  input  wire logic signed [W-1:0] b_y,
  input  wire logic signed [W-1:0] b_z,
  input  wire logic signed [W-1:0] scale_value,
  output logic                    done,
  output logic signed [W-1:0]     res_x,
  output logic signed [W-1:0]     res_y,
  output logic signed [W-1:0]     res_z,
  output logic signed [W-1:0]     res_scalar,
  output logic                    overflow,
  output logic                    div_zero
);

  assign busy = rst;

  // Front stages
  sq_t sq_pipe [W+1];

  v3au_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start & ~busy),
    .in_func (func),
    .in_a    ({a_z, a_y, a_x}),
    .in_b    ({b_z, b_y, b_x}),
    .in_s    (scale_value),
    .out     (sq_pipe[0])
  );

  // Square root chain, one root bit per stage
  for (genvar k = 0; k < W; k++) begin : g_sqrt
    v3au_sqrt_stage u_sq (
      .clk (clk),
      .rst (rst),
      .d   (sq_pipe[k]),
      .q   (sq_pipe[k+1])
    );
  end

  // Settle magnitude result and load the dividers
  dv_t  dv_pipe [NW+1];
  pay_t mpay;
  sat_t msat;

  always_comb begin
    mpay = sq_pipe[W].pay;
    msat = sat_mag(sq_pipe[W].root);
    if (mpay.func == OP_MAG) begin
      mpay.sc  = msat.val;
      mpay.ovf = msat.ovf;
    end
    if (mpay.func == OP_NORM) begin
      for (int i = 0; i < 3; i++) begin
        mpay.dsr[i]     = sq_pipe[W].root;
        mpay.dsr_neg[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_pipe[0].vld <= 1'b0;
    end else begin
      dv_pipe[0].vld <= sq_pipe[W].vld;
    end
    for (int i = 0; i < 3; i++) begin
      dv_pipe[0].lane[i].rem <= '0;
      dv_pipe[0].lane[i].num <= mpay.dvd[i];
    end
    dv_pipe[0].pay <= mpay;
  end

  // Divider chain, one quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_div
    v3au_div_stage u_dv (
      .clk (clk),
      .rst (rst),
      .d   (dv_pipe[k]),
      .q   (dv_pipe[k+1])
    );
  end

  // Final selection and output register
  pay_t              fpay;
  logic [2:0][W-1:0] fr;
  logic              fovf;
  logic              fdz;
  sat_t              qs [3];

  always_comb begin
    fpay = dv_pipe[NW].pay;
    fr   = fpay.r;
    fovf = fpay.ovf;
    fdz  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      qs[i] = sat_quo(dv_pipe[NW].lane[i].num, fpay.dvd_neg[i] ^ fpay.dsr_neg[i]);
      if (is_div_op(fpay.func)) begin
        if (fpay.dsr[i] == '0) begin
          fr[i] = '0;
          fdz   = 1'b1;
        end else begin
          fr[i] = qs[i].val;
          fovf  = fovf | qs[i].ovf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_pipe[NW].vld;
    end
    res_x      <= fr[0];
    res_y      <= fr[1];
    res_z      <= fr[2];
    res_scalar <= fpay.sc;
    overflow   <= fovf;
    div_zero   <= fdz;
  end

`ifndef SYNTHESIS
  // Every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(start && !busy, LATENCY + 1) |-> done)
    else $error("result missing at fixed latency");

  // Scalar and vector results never come from the same opcode
  a_scalar_excl: assert property (@(posedge clk) disable iff (rst)
    (done && res_scalar != '0) |-> (res_x == '0 && res_y == '0 && res_z == '0))
    else $error("scalar and vector result both nonzero");

  // Divide-by-zero never coincides with a scalar result
  a_dz_vector: assert property (@(posedge clk) disable iff (rst)
    (done && div_zero) |-> (res_scalar == '0))
    else $error("div_zero raised on a scalar opcode");
`endif

endmodule
`default_nettype wire
